/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker file of the field parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define FWIP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwip assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define FWIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwip assertion failed");

`endif

/* hdl/fwip_pkg.sv */
// Types and constants of the fixed-width integer field parser.
`default_nettype none

package fwip_pkg;

    // Parse phase codes.
    localparam logic [1:0] PH_LEAD    = 2'd0;
    localparam logic [1:0] PH_DIGITS  = 2'd1;
    localparam logic [1:0] PH_SWALLOW = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FIELD_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_NUMBER_BASE   = 2'd1;
    localparam logic [1:0] CFG_BLANK_AS_ZERO = 2'd2;

    // Configuration reset values.
    localparam logic [5:0] FIELD_WIDTH_RESET   = 6'd8;
    localparam logic [3:0] NUMBER_BASE_RESET   = 4'd10;
    localparam logic       BLANK_AS_ZERO_RESET = 1'b0;

    // Character codes.
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [5:0] field_width;
        logic [3:0] number_base;
        logic       blank_as_zero;
    } fwip_cfg_t;

    typedef struct packed {
        logic [1:0]  parse_phase;
        logic [5:0]  width_left;
        logic        negative;
        logic [63:0] accumulator;
        logic        bad_seen;
    } fwip_state_t;

    localparam fwip_state_t STATE_RESET = '{
        parse_phase: PH_LEAD,
        width_left:  6'd0,
        negative:    1'b0,
        accumulator: 64'd0,
        bad_seen:    1'b0
    };

endpackage

`default_nettype wire

/* hdl/fwip_char_if.sv */
// Channel interfaces: input characters and finished field results.
`default_nettype none

interface fwip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface fwip_field_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] field_value;
    logic               field_status;

    modport source (output valid, output field_value, output field_status, input ready);
    modport sink (input valid, input field_value, input field_status, output ready);
endinterface

`default_nettype wire

/* hdl/fwip_step.sv */
// Next-state logic of the parser for one character.
`default_nettype none

module fwip_step
    import fwip_pkg::*;
(
    input  wire fwip_state_t cur,
    input  wire fwip_cfg_t   cfg,
    input  wire [7:0]        char_in,
    output fwip_state_t      nxt,
    output logic             emit,
    output logic [63:0]      value,
    output logic             status
);

    logic        is_digit;
    logic [3:0]  digit_val;
    logic [63:0] acc_scaled;
    logic [5:0]  width_eff;
    logic        last_unit;
    logic [1:0]  ph_v;
    logic [5:0]  wl_v;
    logic        neg_v;
    logic [63:0] acc_v;
    logic        bad_v;

    // Character class and the shared multiply by the base.
    assign is_digit   = (char_in inside {[CH_ZERO:CH_NINE]});
    assign digit_val  = 4'(char_in - CH_ZERO);
    assign acc_scaled = cur.accumulator * {60'd0, cfg.number_base};

    // The width is loaded on the first character that uses it.
    always_comb
    begin
        if (cur.width_left == 6'd0)
        begin
            width_eff = (cfg.field_width == 6'd0) ? 6'd1 : cfg.field_width;
        end
        else
        begin
            width_eff = cur.width_left;
        end
    end

    assign last_unit = (width_eff <= 6'd1);

    // Phase decode for the current character.
    always_comb
    begin
        ph_v  = cur.parse_phase;
        wl_v  = cur.width_left;
        neg_v = cur.negative;
        acc_v = cur.accumulator;
        bad_v = cur.bad_seen;
        emit  = 1'b0;
        case (cur.parse_phase)
            PH_SWALLOW:
            begin
                emit = last_unit;
                wl_v = width_eff - 6'd1;
            end
            PH_DIGITS:
            begin
                if (is_digit || char_in == CH_SPACE)
                begin
                    if (is_digit)
                    begin
                        acc_v = acc_scaled + {60'd0, digit_val};
                    end
                    else if (cfg.blank_as_zero)
                    begin
                        acc_v = acc_scaled;
                    end
                    emit = last_unit;
                    wl_v = width_eff - 6'd1;
                end
                else if (char_in == CH_LF || char_in == CH_COMMA)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    bad_v = 1'b1;
                    emit  = last_unit;
                    wl_v  = width_eff - 6'd1;
                    ph_v  = PH_SWALLOW;
                end
            end
            default:
            begin
                if (char_in == CH_LF || char_in == CH_CR)
                begin
                    // Line breaks before the field starts are dropped.
                    wl_v = cur.width_left;
                end
                else if (char_in == CH_SPACE)
                begin
                    emit = last_unit;
                    wl_v = width_eff - 6'd1;
                end
                else if (char_in == CH_COMMA)
                begin
                    emit = 1'b1;
                end
                else if (char_in == CH_MINUS || char_in == CH_PLUS || is_digit)
                begin
                    if (char_in == CH_MINUS)
                    begin
                        neg_v = 1'b1;
                    end
                    if (is_digit)
                    begin
                        acc_v = {60'd0, digit_val};
                    end
                    emit = last_unit;
                    wl_v = width_eff - 6'd1;
                    ph_v = PH_DIGITS;
                end
                else
                begin
                    bad_v = 1'b1;
                    emit  = last_unit;
                    wl_v  = width_eff - 6'd1;
                    ph_v  = PH_SWALLOW;
                end
            end
        endcase
    end

    // Result value and the state that follows.
    assign value  = neg_v ? (64'd0 - acc_v) : acc_v;
    assign status = bad_v;

    always_comb
    begin
        if (emit)
        begin
            nxt = STATE_RESET;
        end
        else
        begin
            nxt.parse_phase = ph_v;
            nxt.width_left  = wl_v;
            nxt.negative    = neg_v;
            nxt.accumulator = acc_v;
            nxt.bad_seen    = bad_v;
        end
    end

endmodule

`default_nettype wire

/* hdl/fixed_width_integer_field_parser_core.sv */
// A transferred character is held in the input register and parsed into the parse state when
// the step fires; a field result it completes is offered from the result register.
// Throughput: one character per cycle while no result stalls; one 64-bit multiply-add each.
// The output register lets a new character enter while a result still waits to be taken.
// Reset: asynchronous, active low; clears the parse state and restores the
// configuration to width 8, base 10 and blanks skipped.
`default_nettype none

module fixed_width_integer_field_parser_core
    import fwip_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    fwip_char_if.sink    char_chan,
    fwip_field_if.source field_chan,
    input  wire          cfg_we,
    input  wire [1:0]    cfg_index,
    input  wire [5:0]    cfg_data
);

    fwip_cfg_t   cfg_reg;
    fwip_state_t state_reg;
    fwip_state_t state_next;
    logic        char_valid_reg;
    logic [7:0]  char_reg;
    logic        out_valid_reg;
    logic [63:0] out_value_reg;
    logic        out_status_reg;
    logic        step_fire;
    logic        step_emit;
    logic [63:0] step_value;
    logic        step_status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_width   <= FIELD_WIDTH_RESET;
            cfg_reg.number_base   <= NUMBER_BASE_RESET;
            cfg_reg.blank_as_zero <= BLANK_AS_ZERO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIELD_WIDTH:   cfg_reg.field_width   <= cfg_data;
                CFG_NUMBER_BASE:   cfg_reg.number_base   <= cfg_data[3:0];
                CFG_BLANK_AS_ZERO: cfg_reg.blank_as_zero <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // The parse step runs when a character is held and the result slot is free or draining.
    assign step_fire       = char_valid_reg && (!out_valid_reg || field_chan.ready);
    assign char_chan.ready = !char_valid_reg || step_fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (char_chan.ready)
        begin
            char_valid_reg <= char_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
        begin
            char_reg <= char_chan.char_in;
        end
    end

    fwip_step u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .char_in (char_reg),
        .nxt     (state_next),
        .emit    (step_emit),
        .value   (step_value),
        .status  (step_status)
    );

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire && step_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (field_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && step_emit)
        begin
            out_value_reg  <= step_value;
            out_status_reg <= step_status;
        end
    end

    assign field_chan.valid        = out_valid_reg;
    assign field_chan.field_value  = out_value_reg;
    assign field_chan.field_status = out_status_reg;

endmodule

`default_nettype wire

/* hdl/fwip_checker.sv */
// Port-level checks of the field parser, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module fwip_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [63:0] out_value,
    input wire        out_status
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // A stalled result keeps its payload.
    `FWIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status))

    // With the result slot empty the parser always takes a character.
    `FWIP_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // A fresh result follows a character transfer through the input register and the result register.
    `FWIP_ASSERT_SAME(a_result_cause, clk, rst_n, $rose(out_valid), $past(in_xfer, 2))

endmodule

bind fixed_width_integer_field_parser_core fwip_checker u_fwip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (char_chan.valid),
    .in_ready   (char_chan.ready),
    .out_valid  (field_chan.valid),
    .out_ready  (field_chan.ready),
    .out_value  (field_chan.field_value),
    .out_status (field_chan.field_status)
);

`default_nettype wire

/* sim/fwip_field_checker.sv */
// Checker for the field parser: predicts field results from the character stream and compares.
`default_nettype none

module fwip_field_checker
    import fwip_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    fwip_char_if        char_chan,
    fwip_field_if       field_chan,
    input  wire         cfg_we,
    input  wire [1:0]   cfg_index,
    input  wire [5:0]   cfg_data,
    output int unsigned mismatch_count,
    output int unsigned open_count
);

    typedef struct packed {
        logic signed [63:0] value;
        logic               status;
    } field_result_t;

    fwip_cfg_t     cfg;
    fwip_state_t   ps;
    field_result_t due_fields [$];
    int unsigned   error_total;

    // Advance the parse state by one character; done is set when a field finishes.
    function automatic void parse_char(input logic [7:0] c, output logic done,
                                       output field_result_t res);
        logic       is_digit;
        logic       use_unit;
        logic       finish;
        logic [1:0] next_phase;
        logic [63:0] base_ext;
        logic [63:0] digit_ext;
        is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        use_unit   = 1'b0;
        finish     = 1'b0;
        next_phase = ps.parse_phase;
        base_ext   = {60'd0, cfg.number_base};
        digit_ext  = {56'd0, c - CH_ZERO};
        res        = '0;

        case (ps.parse_phase)
            PH_SWALLOW:
            begin
                use_unit = 1'b1;
            end
            PH_DIGITS:
            begin
                if (is_digit) begin
                    ps.accumulator = ps.accumulator * base_ext + digit_ext;
                    use_unit = 1'b1;
                end else if (c == CH_SPACE) begin
                    if (cfg.blank_as_zero) ps.accumulator = ps.accumulator * base_ext;
                    use_unit = 1'b1;
                end else if (c == CH_LF || c == CH_COMMA) begin
                    finish = 1'b1;
                end else begin
                    ps.bad_seen = 1'b1;
                    use_unit    = 1'b1;
                    next_phase  = PH_SWALLOW;
                end
            end
            default:
            begin
                // Line breaks before the first non-blank use no width.
                if (c != CH_LF && c != CH_CR) begin
                    if (ps.width_left == 6'd0)
                        ps.width_left = (cfg.field_width == 6'd0) ? 6'd1 : cfg.field_width;
                    if (c == CH_SPACE) begin
                        use_unit = 1'b1;
                    end else if (c == CH_COMMA) begin
                        finish = 1'b1;
                    end else if (c == CH_MINUS) begin
                        ps.negative = 1'b1;
                        use_unit    = 1'b1;
                        next_phase  = PH_DIGITS;
                    end else if (c == CH_PLUS) begin
                        use_unit   = 1'b1;
                        next_phase = PH_DIGITS;
                    end else if (is_digit) begin
                        ps.accumulator = digit_ext;
                        use_unit       = 1'b1;
                        next_phase     = PH_DIGITS;
                    end else begin
                        ps.bad_seen = 1'b1;
                        use_unit    = 1'b1;
                        next_phase  = PH_SWALLOW;
                    end
                end
            end
        endcase

        // A character that uses the last width unit ends the field.
        if (use_unit) begin
            if (ps.width_left <= 6'd1) begin
                finish = 1'b1;
            end else begin
                ps.width_left  = ps.width_left - 6'd1;
                ps.parse_phase = next_phase;
            end
        end

        done = finish;
        if (finish) begin
            res.value  = ps.negative ? (64'd0 - ps.accumulator) : ps.accumulator;
            res.status = ps.bad_seen;
            ps         = STATE_RESET;
        end
    endfunction

    // Compare result transfers, track configuration writes, predict from character transfers.
    always @(posedge clk or negedge rst_n) begin : monitor
        field_result_t got;
        field_result_t want;
        logic          done;
        if (!rst_n) begin
            cfg.field_width   = FIELD_WIDTH_RESET;
            cfg.number_base   = NUMBER_BASE_RESET;
            cfg.blank_as_zero = BLANK_AS_ZERO_RESET;
            ps                = STATE_RESET;
            due_fields.delete();
            error_total       = 0;
            mismatch_count   <= 0;
            open_count       <= 0;
        end else begin
            if (field_chan.valid && field_chan.ready) begin
                got.value  = field_chan.field_value;
                got.status = field_chan.field_status;
                if (due_fields.size() == 0) begin
                    $display("%0t: unexpected field result, value %0d status %0d",
                             $time, got.value, got.status);
                    error_total++;
                end else begin
                    want = due_fields.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: field_value expected %0d actual %0d",
                                 $time, want.value, got.value);
                        error_total++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: field_status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        error_total++;
                    end
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_FIELD_WIDTH:   cfg.field_width   = cfg_data;
                    CFG_NUMBER_BASE:   cfg.number_base   = cfg_data[3:0];
                    CFG_BLANK_AS_ZERO: cfg.blank_as_zero = cfg_data[0];
                    default:           ;
                endcase
            end

            if (char_chan.valid && char_chan.ready) begin
                parse_char(char_chan.char_in, done, want);
                if (done) due_fields.push_back(want);
            end

            mismatch_count <= error_total;
            open_count     <= due_fields.size();
        end
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench top for the field parser: clock, reset, character stimulus, configuration and verdict.
`default_nettype none

module tb_top
    import fwip_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_CHARS   = 110;

    // Directed text, parsed with width 4, base 10 and blanks skipped.
    localparam logic [7:0] DIRECTED_TEXT [26] = '{
        // All blanks.
        CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE,
        // Comma as the first non-blank.
        CH_COMMA,
        // Negative value ended early by a newline.
        CH_MINUS, CH_ZERO + 8'd9, CH_LF,
        // Line breaks ignored before the sign, then a trailing blank.
        CH_CR, CH_LF, CH_PLUS, CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_SPACE,
        // Bad character, then the rest of the width swallowed.
        CH_ZERO + 8'd1, 8'hFF, 8'h00, CH_ZERO + 8'd9,
        // Sign alone at the end of the width.
        CH_SPACE, CH_SPACE, CH_SPACE, CH_MINUS,
        // Carriage return inside the digits is bad.
        CH_ZERO + 8'd5, CH_CR, 8'h61, 8'h62
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    int unsigned mismatch_count;
    int unsigned open_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned chars_sent;

    fwip_char_if  char_chan ();
    fwip_field_if field_chan ();

    fixed_width_integer_field_parser_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_chan  (char_chan),
        .field_chan (field_chan),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    fwip_field_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_chan      (char_chan),
        .field_chan     (field_chan),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .open_count     (open_count)
    );

    // Clock with a period of two time units.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result receiver stalls at the rate of the current phase.
    always @(posedge clk) begin
        field_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Cycle counter that ends a run that hangs.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one character, with random idle cycles first, and hold it until it transfers.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            char_chan.valid <= 1'b0;
            @(posedge clk);
        end
        char_chan.valid   <= 1'b1;
        char_chan.char_in <= c;
        @(posedge clk);
        while (!char_chan.ready) @(posedge clk);
        chars_sent++;
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic wait_idle();
        char_chan.valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges.
    task automatic load_config(input logic [5:0] width, input logic [3:0] base,
                               input logic blank);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIELD_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_index <= CFG_NUMBER_BASE;
        cfg_data  <= {2'b00, base};
        @(posedge clk);
        cfg_index <= CFG_BLANK_AS_ZERO;
        cfg_data  <= {5'd0, blank};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One field of random content: mostly well formed, some noise and bad characters.
    task automatic send_field(input int width);
        int         kind;
        int         lead;
        int         r;
        logic [7:0] c;
        kind = $urandom_range(99);
        if (kind < 8) begin
            send_char(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(7) == 0) send_char($urandom_range(1) ? CH_CR : CH_LF);
        lead = $urandom_range(width / 2);
        for (int i = 0; i < width; i++) begin
            r = $urandom_range(99);
            if (i < lead)
                c = CH_SPACE;
            else if (i == lead && r < 30)
                c = (r < 15) ? CH_MINUS : CH_PLUS;
            else if (r < 74)
                c = CH_ZERO + 8'($urandom_range(9));
            else if (r < 86)
                c = CH_SPACE;
            else if (r < 91)
                c = $urandom_range(1) ? CH_COMMA : CH_LF;
            else if (kind < 30)
                c = 8'($urandom_range(255));
            else
                c = CH_ZERO + 8'($urandom_range(9));
            send_char(c);
            if (c == CH_COMMA || c == CH_LF) break;
        end
    endtask

    // Main stimulus: reset, directed text, then random phases.
    initial begin : stimulus
        logic [5:0]  width;
        logic [3:0]  base;
        logic        blank;
        int unsigned start;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_FIELD_WIDTH;
        cfg_data          = 6'd0;
        char_chan.valid   = 1'b0;
        char_chan.char_in = 8'd0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        chars_sent        = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_config(6'd4, 4'd10, 1'b0);
        foreach (DIRECTED_TEXT[i]) send_char(DIRECTED_TEXT[i]);

        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase)
                0: begin width = 6'd8;  base = 4'd10; blank = 1'b0; end
                1: begin width = 6'd1;  base = 4'd2;  blank = 1'b1; end
                2: begin width = 6'd32; base = 4'd10; blank = 1'b1; end
                3: begin width = 6'd5;  base = 4'd15; blank = 1'b0; end
                4: begin width = 6'd0;  base = 4'd0;  blank = 1'b1; end
                5: begin width = 6'd63; base = 4'd1;  blank = 1'b0; end
                6:
                begin
                    width = 6'($urandom_range(32, 1));
                    base  = 4'($urandom_range(10, 2));
                    blank = 1'($urandom_range(1));
                end
                default:
                begin
                    width = 6'($urandom_range(12, 1));
                    base  = 4'($urandom_range(10, 2));
                    blank = 1'($urandom_range(1));
                end
            endcase
            load_config(width, base, blank);

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase

            // Two halves, with the sender holding off until all results are in between.
            repeat (2) begin
                start = chars_sent;
                while (chars_sent - start < PHASE_CHARS)
                    send_field((width == 6'd0) ? 1 : int'(width));
                wait_idle();
            end
        end

        wait_idle();
        if (mismatch_count == 0 && open_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
